// File: src/lpht_pkg.sv
// Shared constants, codes, control structs and a helper function for the hash table.
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

  localparam int CAPACITY   = 16;
  localparam int KEY_W      = 40;
  localparam int SLOT_W     = 4;
  localparam int CNT_W      = 5;
  localparam int DIV_STEPS  = KEY_W;
  localparam int DIV_CNT_W  = 6;

  // Action codes of an input word.
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_SEARCH = 2'd2;

  // Status codes of a result word.
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_PRESENT  = 2'd1;
  localparam logic [1:0] ST_NO_ROOM  = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // Slot marks.
  localparam logic [1:0] MARK_EMPTY   = 2'd0;
  localparam logic [1:0] MARK_ACTIVE  = 2'd1;
  localparam logic [1:0] MARK_DELETED = 2'd2;

  // Configuration register indexes.
  localparam logic REG_DIVISOR    = 1'b0;
  localparam logic REG_TABLE_SIZE = 1'b1;

  typedef struct packed {
    logic load;
    logic div_step;
    logic home_load;
    logic probe_rd;
    logic probe_chk;
    logic finish;
  } lpht_cmd_t;

  typedef struct packed {
    logic div_last;
    logic full_insert;
    logic probe_done;
  } lpht_stat_t;

  // Remainder of a small value (below ten) by a table size of 1 to 16,
  // worked out as a four-step restoring reduction.
  function automatic logic [SLOT_W-1:0] mod_small(input logic [3:0] h,
                                                  input logic [CNT_W-1:0] s);
    logic [CNT_W-1:0] r;
    r = '0;
    for (int i = 3; i >= 0; i--) begin
      r = {r[CNT_W-2:0], h[i]};
      if (r >= s) begin
        r = r - s;
      end
    end
    return r[SLOT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: src/lpht_ctrl.sv
// Controller state machine that sequences division, home slot, probing and update.
`timescale 1ns / 1ps
`default_nettype none

module lpht_ctrl
  import lpht_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire lpht_stat_t stat,
  output lpht_cmd_t       cmd,
  output logic            busy
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DIV    = 6'b000010,
    S_HOME   = 6'b000100,
    S_PRB_RD = 6'b001000,
    S_PRB_CK = 6'b010000,
    S_FINISH = 6'b100000
  } lpht_state_t;

  lpht_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_HOME;
        end
      end
      S_HOME: begin
        cmd.home_load = 1'b1;
        state_next    = stat.full_insert ? S_FINISH : S_PRB_RD;
      end
      S_PRB_RD: begin
        cmd.probe_rd = 1'b1;
        state_next   = S_PRB_CK;
      end
      S_PRB_CK: begin
        cmd.probe_chk = 1'b1;
        state_next    = stat.probe_done ? S_FINISH : S_PRB_RD;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

// File: src/lpht_dp.sv
// Datapath: configuration, serial divider, slot marks, key memory and result registers.
`timescale 1ns / 1ps
`default_nettype none

module lpht_dp
  import lpht_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire logic              cfg_index,
  input  wire logic [KEY_W-1:0]  cfg_data,
  input  wire logic [1:0]        action,
  input  wire logic [KEY_W-1:0]  key,
  input  wire lpht_cmd_t         cmd,
  output lpht_stat_t             stat,
  output logic                   done,
  output logic                   ok,
  output logic [1:0]             status_code,
  output logic [SLOT_W-1:0]      slot,
  output logic [CNT_W-1:0]       occupancy
);

  logic [KEY_W-1:0]     divisor;
  logic [CNT_W-1:0]     table_size;
  logic [CNT_W-1:0]     eff_size;

  logic [1:0]           act_q;
  logic [KEY_W-1:0]     key_q;
  logic [KEY_W-1:0]     dvd;
  logic [KEY_W-1:0]     dvs;
  logic [KEY_W-1:0]     rem;
  logic [3:0]           m10;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic [SLOT_W-1:0]    home;
  logic [SLOT_W-1:0]    j;
  logic [SLOT_W-1:0]    n;
  logic [SLOT_W-1:0]    s_q;
  logic                 hit_q;
  logic                 full_q;
  logic [1:0]           mark_q;
  logic [KEY_W-1:0]     rd_key;

  logic [1:0]           marks [CAPACITY];
  logic [KEY_W-1:0]     keys  [CAPACITY];
  logic [CNT_W-1:0]     count;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      divisor    <= KEY_W'(1);
      table_size <= CNT_W'(CAPACITY);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DIVISOR:    divisor    <= cfg_data;
        REG_TABLE_SIZE: table_size <= cfg_data[CNT_W-1:0];
        default:        divisor    <= divisor;
      endcase
    end
  end

  always_comb begin
    if (table_size == '0) begin
      eff_size = CNT_W'(1);
    end else if (table_size > CNT_W'(CAPACITY)) begin
      eff_size = CNT_W'(CAPACITY);
    end else begin
      eff_size = table_size;
    end
  end

  // Restoring divider step; the quotient is only needed mod ten, so its
  // bits are folded into a running remainder as they come out.
  logic [KEY_W:0]   rem_sh;
  logic [KEY_W+1:0] diff;
  logic             q_bit;
  logic [4:0]       m2;

  always_comb begin
    rem_sh = {rem, dvd[KEY_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dvs};
    q_bit  = ~diff[KEY_W+1];
    m2     = {m10, 1'b0} + {4'd0, q_bit};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q   <= action;
      key_q   <= key;
      dvd     <= key;
      dvs     <= (divisor == '0) ? KEY_W'(1) : divisor;
      rem     <= '0;
      m10     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= q_bit ? diff[KEY_W-1:0] : rem_sh[KEY_W-1:0];
      dvd     <= {dvd[KEY_W-2:0], 1'b0};
      m10     <= (m2 >= 5'd10) ? 4'(m2 - 5'd10) : m2[3:0];
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  // Probe sequencing.
  logic                 full_insert;
  logic                 key_match;
  logic                 stop;
  logic                 lap;
  logic [CNT_W-1:0]     j_inc;

  always_comb begin
    full_insert = (act_q == ACT_INSERT) && (count >= eff_size);
    key_match   = (rd_key == key_q);
    stop        = (mark_q == MARK_EMPTY) || ((mark_q == MARK_ACTIVE) && key_match);
    lap         = ({1'b0, n} == (eff_size - CNT_W'(1)));
    j_inc       = {1'b0, j} + CNT_W'(1);
  end

  assign stat.div_last    = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
  assign stat.full_insert = full_insert;
  assign stat.probe_done  = stop || lap;

  always_ff @(posedge clk) begin
    if (cmd.home_load) begin
      home   <= mod_small(m10, eff_size);
      j      <= mod_small(m10, eff_size);
      s_q    <= mod_small(m10, eff_size);
      n      <= '0;
      hit_q  <= 1'b0;
      full_q <= full_insert;
    end else if (cmd.probe_rd) begin
      mark_q <= marks[j];
    end else if (cmd.probe_chk) begin
      if (stop) begin
        s_q   <= j;
        hit_q <= (mark_q == MARK_ACTIVE) && key_match;
      end else if (lap) begin
        s_q   <= home;
        hit_q <= 1'b0;
      end else begin
        j <= (j_inc == eff_size) ? '0 : j_inc[SLOT_W-1:0];
        n <= n + SLOT_W'(1);
      end
    end
  end

  // Final update of the store and the result word.
  logic [1:0]       mark_s;
  logic             ins_ok;
  logic             rem_ok;
  logic             res_ok;
  logic [1:0]       res_st;
  logic [CNT_W-1:0] count_next;

  always_comb begin
    mark_s = marks[s_q];
    ins_ok = (act_q == ACT_INSERT) && !full_q && (mark_s != MARK_ACTIVE);
    rem_ok = (act_q == ACT_REMOVE) && hit_q;
    res_ok = 1'b0;
    res_st = ST_NOTFOUND;
    case (act_q)
      ACT_INSERT: begin
        if (ins_ok) begin
          res_ok = 1'b1;
          res_st = ST_DONE;
        end else if (!full_q && hit_q) begin
          res_st = ST_PRESENT;
        end else begin
          res_st = ST_NO_ROOM;
        end
      end
      default: begin
        // Remove, search and the unused code all report a hit the same way.
        if (hit_q) begin
          res_ok = 1'b1;
          res_st = ST_DONE;
        end
      end
    endcase
    if (ins_ok) begin
      count_next = count + CNT_W'(1);
    end else if (rem_ok && (count != '0)) begin
      count_next = count - CNT_W'(1);
    end else begin
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        marks[i] <= MARK_EMPTY;
      end
    end else if (cmd.finish) begin
      count <= count_next;
      if (ins_ok) begin
        marks[s_q] <= MARK_ACTIVE;
      end else if (rem_ok) begin
        marks[s_q] <= MARK_DELETED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && ins_ok) begin
      keys[s_q] <= key_q;
    end
    if (cmd.probe_rd) begin
      rd_key <= keys[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      ok          <= res_ok;
      status_code <= res_st;
      slot        <= s_q;
      occupancy   <= count_next;
    end
  end

endmodule

`default_nettype wire

// File: src/linear_probe_hash_table.sv
// Top level of the linear-probing hash table: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none

// A command word is taken when start is high and busy is low; busy then stays
// high until the result word is shown for one cycle on done, which cannot be
// held off. After the edge that accepts the command, the block works through
// these steps in order: the one-bit-per-cycle divider finds the home slot, it
// is reduced to the table size, each of the P probed slots (1 to the table
// size, none for an insert into a full table) is read from the key memory by
// a registered read and then checked, and the store is updated. A new command
// may be started in the cycle that shows done.
// Configuration writes are taken at once and belong in idle periods.
module linear_probe_hash_table
  import lpht_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire logic              cfg_index,
  input  wire logic [KEY_W-1:0]  cfg_data,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        action,
  input  wire logic [KEY_W-1:0]  key,
  output logic                   done,
  output logic                   ok,
  output logic [1:0]             status_code,
  output logic [SLOT_W-1:0]      slot,
  output logic [CNT_W-1:0]       occupancy
);

  lpht_cmd_t  cmd;
  lpht_stat_t stat;

  lpht_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  lpht_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .action      (action),
    .key         (key),
    .cmd         (cmd),
    .stat        (stat),
    .done        (done),
    .ok          (ok),
    .status_code (status_code),
    .slot        (slot),
    .occupancy   (occupancy)
  );

endmodule

`default_nettype wire

// File: src/lpht_chk.sv
// Port-level checker for the hash table and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module lpht_chk
  import lpht_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             done,
  input wire logic             ok,
  input wire logic [1:0]       status_code,
  input wire logic [CNT_W-1:0] occupancy
);

  // An accepted word keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // A result word is shown only once the block is free again.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // Every item takes many cycles, so results never come back to back.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  // Success and the done code go together.
  a_ok_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (ok == (status_code == ST_DONE)))
    else $error("ok flag disagrees with status code");

  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (occupancy <= CNT_W'(CAPACITY)))
    else $error("occupancy above capacity");

endmodule

bind linear_probe_hash_table lpht_chk u_lpht_chk (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .ok          (ok),
  .status_code (status_code),
  .occupancy   (occupancy)
);

`default_nettype wire
